// ----- hdl/lrr_pkg.sv -----
// Package for the Lehmer random generator with ranged output.
// Holds request codes, queue entry type, back-end states and constants.
// No dependencies.
package lrr_pkg;

  localparam logic [30:0] LehmerMod  = 31'h7FFF_FFFF;
  localparam logic [15:0] LehmerMul  = 16'd48271;
  localparam logic [31:0] ReseedMask = 32'hAAAA_AAAA;

  localparam int unsigned DefaultQueueDepth = 2;

  localparam int unsigned RawWidth = 31;
  localparam int unsigned CntWidth = $clog2(RawWidth);

  typedef enum logic [1:0] {
    REQ_NEXT          = 2'd0,
    REQ_RESEED_MASK   = 2'd1,
    REQ_RESEED_DIRECT = 2'd2
  } req_type_e;

  typedef enum logic {
    JOB_NEXT   = 1'b0,
    JOB_RESEED = 1'b1
  } job_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic               err;
    logic [30:0]        span;
    logic signed [31:0] low;
    logic [31:0]        seed;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_REDUCE,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

// ----- hdl/lrr_front.sv -----
// Front end: accepts request transfers, decodes them and checks the range.
// Pushes one job per next or reseed request into the queue.
// Depends on lrr_pkg.
module lrr_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic signed [31:0]  range_low_i,
  input  logic signed [31:0]  range_high_i,
  input  logic [31:0]         seed_value_i,
  input  logic                full_i,
  output logic                push_o,
  output lrr_pkg::job_t       job_o
);

  logic signed [33:0] low_ext;
  logic signed [33:0] high_ext;
  logic signed [33:0] span;
  logic               span_bad;
  logic               take;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;

  assign low_ext  = 34'(range_low_i);
  assign high_ext = 34'(range_high_i);
  assign span     = high_ext - low_ext + 34'sd1;
  assign span_bad = (span <= 34'sd0) ||
                    (span > $signed({3'b000, lrr_pkg::LehmerMod}));

  always_comb begin
    job_o.kind = lrr_pkg::JOB_NEXT;
    job_o.err  = span_bad;
    job_o.span = span[30:0];
    job_o.low  = range_low_i;
    job_o.seed = seed_value_i;
    push_o     = 1'b0;
    case (req_type_i)
      lrr_pkg::REQ_NEXT: begin
        push_o = take;
      end
      lrr_pkg::REQ_RESEED_MASK: begin
        job_o.kind = lrr_pkg::JOB_RESEED;
        job_o.seed = seed_value_i ^ lrr_pkg::ReseedMask;
        push_o     = take;
      end
      lrr_pkg::REQ_RESEED_DIRECT: begin
        job_o.kind = lrr_pkg::JOB_RESEED;
        push_o     = take;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/lrr_queue.sv -----
// Short job queue between the front end and the back end.
// Register array with read and write pointers. Depends on lrr_pkg.
module lrr_queue #(
  parameter int unsigned Depth = lrr_pkg::DefaultQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lrr_pkg::job_t job_i,
  input  logic          pop_i,
  output lrr_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  lrr_pkg::job_t         mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ----- hdl/lrr_back.sv -----
// Back end: holds the seed, advances it modulo 2^31-1 and reduces the
// result into the requested range with a bit-serial divider.
// Depends on lrr_pkg.
module lrr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  lrr_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        raw_value_o,
  output logic signed [31:0] ranged_value_o,
  output logic               range_error_o
);

  lrr_pkg::back_state_e state_q, state_d;

  logic [31:0]                  seed_q, seed_d;
  logic [47:0]                  prod_q, prod_d;
  logic [30:0]                  raw_q, raw_d;
  logic [31:0]                  rem_q, rem_d;
  logic [lrr_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic [30:0]                  span_q, span_d;
  logic signed [31:0]           low_q, low_d;
  logic                         err_q, err_d;

  logic                         out_valid_q, out_valid_d;
  logic [30:0]                  out_raw_q, out_raw_d;
  logic signed [31:0]           out_ranged_q, out_ranged_d;
  logic                         out_err_q, out_err_d;

  logic [31:0]                  fold;
  logic [30:0]                  folded;
  logic [31:0]                  trial;
  logic                         load_out;

  assign fold  = {1'b0, prod_q[30:0]} + {15'b0, prod_q[47:31]};
  assign trial = {rem_q[30:0], raw_q[cnt_q]};

  always_comb begin
    if (fold > {1'b0, lrr_pkg::LehmerMod}) begin
      folded = 31'(fold - {1'b0, lrr_pkg::LehmerMod});
    end else if (fold == '0) begin
      folded = lrr_pkg::LehmerMod;
    end else begin
      folded = fold[30:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    seed_d   = seed_q;
    prod_d   = prod_q;
    raw_d    = raw_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    span_d   = span_q;
    low_d    = low_q;
    err_d    = err_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      lrr_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (job_i.kind == lrr_pkg::JOB_RESEED) begin
            seed_d = job_i.seed;
          end else begin
            span_d  = job_i.span;
            low_d   = job_i.low;
            err_d   = job_i.err;
            state_d = lrr_pkg::BK_MUL;
          end
        end
      end
      lrr_pkg::BK_MUL: begin
        prod_d  = 48'(lrr_pkg::LehmerMul) * 48'(seed_q);
        state_d = lrr_pkg::BK_REDUCE;
      end
      lrr_pkg::BK_REDUCE: begin
        raw_d   = folded;
        seed_d  = {1'b0, folded};
        rem_d   = '0;
        cnt_d   = lrr_pkg::CntWidth'(lrr_pkg::RawWidth - 1);
        state_d = err_q ? lrr_pkg::BK_DONE : lrr_pkg::BK_DIV;
      end
      lrr_pkg::BK_DIV: begin
        if (trial >= {1'b0, span_q}) begin
          rem_d = trial - {1'b0, span_q};
        end else begin
          rem_d = trial;
        end
        if (cnt_q == '0) begin
          state_d = lrr_pkg::BK_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      lrr_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = lrr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = lrr_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_raw_d    = out_raw_q;
    out_ranged_d = out_ranged_q;
    out_err_d    = out_err_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_raw_d    = raw_q;
      out_err_d    = err_q;
      out_ranged_d = err_q ? low_q : $signed(rem_q + low_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrr_pkg::BK_IDLE;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    raw_q        <= raw_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    span_q       <= span_d;
    low_q        <= low_d;
    err_q        <= err_d;
    out_raw_q    <= out_raw_d;
    out_ranged_q <= out_ranged_d;
    out_err_q    <= out_err_d;
  end

  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = out_raw_q;
  assign ranged_value_o = out_ranged_q;
  assign range_error_o  = out_err_q;

endmodule

// ----- hdl/lehmer_rng_with_range.sv -----
// Top level of the Lehmer random generator with ranged output.
// Connects lrr_front, lrr_queue and lrr_back. Depends on lrr_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  req_type, range_low, range_high, seed_value
//   out      output     out_valid_o/out_ready_i raw_value, ranged_value, range_error
//
// In the back end a next request is taken from the queue, multiplied, folded
// modulo 2^31-1 and passed through 31 steps of the bit-serial divider; the
// result is then loaded into the output register.
// A next request with a bad range skips the divider.
// Reseed requests only load the seed; request code 3 is dropped at the front.
// The front takes transfers while the queue has room; the back end waits
// only when the output register still holds an untaken result.
// Reset clears the seed to zero and empties the queue and output register.
module lehmer_rng_with_range #(
  parameter int unsigned QueueDepth = lrr_pkg::DefaultQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic [31:0]        seed_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        raw_value_o,
  output logic signed [31:0] ranged_value_o,
  output logic               range_error_o
);

  lrr_pkg::job_t push_job;
  lrr_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  lrr_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .seed_value_i (seed_value_i),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  lrr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  lrr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .job_i          (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .raw_value_o    (raw_value_o),
    .ranged_value_o (ranged_value_o),
    .range_error_o  (range_error_o)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Lehmer random generator with ranged output.
// Drives requests with random gaps, predicts every draw and checks each transfer.
// Depends on lrr_pkg and lehmer_rng_with_range.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam int unsigned RANDOM_REQS = 700;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned QUIET_FIRST = 8000;
  localparam int unsigned QUIET_LAST = 16000;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        seed;
  } rng_req_t;

  typedef struct {
    logic [30:0]        raw;
    logic signed [31:0] ranged;
    logic               err;
  } draw_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic signed [31:0] range_low_i;
  logic signed [31:0] range_high_i;
  logic [31:0]        seed_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [30:0]        raw_value_o;
  logic signed [31:0] ranged_value_o;
  logic               range_error_o;

  rng_req_t    pending_reqs[$];
  draw_t       expected_draws[$];
  logic [31:0] model_seed;
  bit          req_taken;
  int unsigned cycle_count;
  int unsigned stall_cycles;
  int unsigned error_count;
  rng_req_t    next_req;

  lehmer_rng_with_range DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .seed_value_i   (seed_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .raw_value_o    (raw_value_o),
    .ranged_value_o (ranged_value_o),
    .range_error_o  (range_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    if (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  // Advances the seed and reduces the new value into the requested range.
  function automatic draw_t predict_draw(logic signed [31:0] lo, logic signed [31:0] hi);
    longint unsigned modulus;
    longint unsigned mult;
    longint unsigned prod;
    longint          span;
    longint          ranged;
    draw_t           d;
    modulus = lrr_pkg::LehmerMod;
    mult = lrr_pkg::LehmerMul;
    prod = (mult * model_seed) % modulus;
    if (prod == 0) prod = modulus;
    model_seed = prod[31:0];
    d.raw = prod[30:0];
    span = longint'(hi) - longint'(lo) + 1;
    if (span <= 0 || span > longint'(modulus)) begin
      d.err = 1'b1;
      d.ranged = lo;
    end else begin
      d.err = 1'b0;
      ranged = longint'(prod % longint'(span)) + longint'(lo);
      d.ranged = ranged[31:0];
    end
    return d;
  endfunction

  task automatic add_req(logic [1:0] kind, logic signed [31:0] lo, logic signed [31:0] hi,
                         logic [31:0] seed);
    rng_req_t r;
    r.kind = kind;
    r.lo = lo;
    r.hi = hi;
    r.seed = seed;
    pending_reqs.push_back(r);
  endtask

  task automatic pick_range(output logic signed [31:0] lo, output logic signed [31:0] hi);
    longint l;
    longint h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        l = longint'($signed($urandom));
        h = l + longint'($urandom_range(0, 999));
      end
      4, 5: begin
        l = longint'($signed($urandom));
        h = longint'($signed($urandom));
      end
      6: begin
        l = longint'($urandom_range(1, 32'h7FFF_FFFF));
        h = l - longint'($urandom_range(1, 100000));
      end
      7: begin
        l = -longint'($urandom_range(0, 32'h7FFF_FFFF));
        h = l + 64'sd2147483646 + longint'($urandom_range(0, 1));
      end
      8: begin
        l = longint'($signed($urandom));
        h = l + (64'sd1 <<< $urandom_range(0, 30)) - 1;
      end
      default: begin
        l = longint'($signed($urandom));
        h = l;
      end
    endcase
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    lo = l[31:0];
    hi = h[31:0];
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFE;
      3: return 32'hFFFF_FFFF;
      4: return lrr_pkg::ReseedMask;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_draws.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver: presents the next pending request after each transfer.
  always @(negedge clk_i) begin
    if (rst_ni && (req_taken || !in_valid_i)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 && !idle_now()) begin
        next_req = pending_reqs.pop_front();
        req_type_i <= next_req.kind;
        range_low_i <= next_req.lo;
        range_high_i <= next_req.hi;
        seed_value_i <= next_req.seed;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && !idle_now();
  end

  // Prediction on each request transfer.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      req_taken = 1'b1;
      if (req_type_i == lrr_pkg::REQ_NEXT) begin
        expected_draws.push_back(predict_draw(range_low_i, range_high_i));
      end else if (req_type_i == lrr_pkg::REQ_RESEED_MASK) begin
        model_seed = seed_value_i ^ lrr_pkg::ReseedMask;
      end else if (req_type_i == lrr_pkg::REQ_RESEED_DIRECT) begin
        model_seed = seed_value_i;
      end
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    draw_t exp_draw;
    cycle_count++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_draws.size() == 0) begin
        $error("Result transfer with no request outstanding: raw_value %0d", raw_value_o);
        error_count++;
      end else begin
        exp_draw = expected_draws.pop_front();
        if (raw_value_o !== exp_draw.raw) begin
          $error("raw_value: expected %0d, got %0d", exp_draw.raw, raw_value_o);
          error_count++;
        end
        if (ranged_value_o !== exp_draw.ranged) begin
          $error("ranged_value: expected %0d, got %0d", exp_draw.ranged, ranged_value_o);
          error_count++;
        end
        if (range_error_o !== exp_draw.err) begin
          $error("range_error: expected %0d, got %0d", exp_draw.err, range_error_o);
          error_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]         kind;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    int unsigned        n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    req_type_i = lrr_pkg::REQ_NEXT;
    range_low_i = '0;
    range_high_i = '0;
    seed_value_i = '0;
    model_seed = '0;
    req_taken = 1'b0;
    cycle_count = 0;
    stall_cycles = 0;
    error_count = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero seed after reset maps to the modulus and stays there.
    add_req(lrr_pkg::REQ_NEXT, 32'sd0, 32'sd9, '0);
    add_req(lrr_pkg::REQ_NEXT, 32'sd0, 32'sd9, '0);
    add_req(lrr_pkg::REQ_RESEED_DIRECT, '0, '0, 32'd1);
    add_req(lrr_pkg::REQ_NEXT, INT_MIN, INT_MAX, '0);
    add_req(lrr_pkg::REQ_NEXT, 32'sd5, 32'sd5, '0);
    add_req(lrr_pkg::REQ_NEXT, 32'sd10, -32'sd10, '0);
    add_req(lrr_pkg::REQ_NEXT, 32'sd0, INT_MAX - 1, '0);
    add_req(lrr_pkg::REQ_NEXT, -32'sd1, INT_MAX, '0);
    add_req(lrr_pkg::REQ_NEXT, 32'sd0, INT_MAX, '0);
    add_req(lrr_pkg::REQ_NEXT, INT_MAX, INT_MAX, '0);
    add_req(lrr_pkg::REQ_NEXT, INT_MIN, INT_MIN, '0);
    add_req(lrr_pkg::REQ_RESEED_MASK, '0, '0, lrr_pkg::ReseedMask);
    add_req(lrr_pkg::REQ_NEXT, INT_MIN, -32'sd2, '0);
    add_req(lrr_pkg::REQ_RESEED_DIRECT, '0, '0, 32'h7FFF_FFFF);
    add_req(lrr_pkg::REQ_NEXT, -32'sd100, 32'sd100, '0);
    add_req(lrr_pkg::REQ_RESEED_DIRECT, '0, '0, 32'hFFFF_FFFE);
    add_req(lrr_pkg::REQ_NEXT, 32'sd1, 32'sd6, '0);
    add_req(lrr_pkg::REQ_RESEED_DIRECT, '0, '0, 32'hFFFF_FFFF);
    add_req(lrr_pkg::REQ_NEXT, 32'sd1, 32'sd6, '0);
    add_req(REQ_UNUSED, INT_MAX, INT_MIN, 32'hFFFF_FFFF);
    add_req(lrr_pkg::REQ_NEXT, INT_MIN, 32'sd0, '0);
    add_req(lrr_pkg::REQ_RESEED_MASK, '0, '0, 32'h5555_5555);
    add_req(lrr_pkg::REQ_NEXT, INT_MIN, -32'sd2, '0);
    add_req(lrr_pkg::REQ_RESEED_DIRECT, '0, '0, 32'h8000_0000);
    add_req(lrr_pkg::REQ_NEXT, -32'sd1, 32'sd0, '0);
    wait_drained();

    n = 0;
    while (n < RANDOM_REQS) begin
      pick_range(lo, hi);
      case ($urandom_range(0, 99)) inside
        [0:73]:  kind = lrr_pkg::REQ_NEXT;
        [74:85]: kind = lrr_pkg::REQ_RESEED_MASK;
        [86:96]: kind = lrr_pkg::REQ_RESEED_DIRECT;
        default: kind = REQ_UNUSED;
      endcase
      add_req(kind, lo, hi, pick_seed());
      if (kind != REQ_UNUSED) begin
        n++;
        if (n % 240 == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
